### rtl/key_click_double_long_detector_macros.svh
// Assertion macros for the key click, double and long press detector.
`ifndef KEY_CLICK_DOUBLE_LONG_DETECTOR_MACROS_SVH
`define KEY_CLICK_DOUBLE_LONG_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KCDL_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("kcdl assertion failed");

// Next-cycle implication, disabled during reset.
`define KCDL_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("kcdl assertion failed");

`endif

### rtl/kcdl_pkg.sv
// Package: types, codes and helpers of the key click, double and long press detector.
package kcdl_pkg;

    localparam int KCDL_KEYS = 32;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [15:0] LONG_RESET     = 16'd1000;
    localparam logic [15:0] DOUBLE_RESET   = 16'd300;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_LONG     = 2'd1,
        CFG_DOUBLE   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        FUNC_SCAN = 1'b0,
        FUNC_READ = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HELD   = 2'd1,
        PH_LONG   = 2'd2,
        PH_DOUBLE = 2'd3
    } t_phase;

    typedef struct packed {
        logic        func;
        logic [31:0] pressed_keys;
        logic [4:0]  read_key;
    } t_in_item;

    typedef struct packed {
        logic [1:0] tick_event;
        logic [4:0] event_key;
        logic [1:0] read_value;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic [4:0] key;
        t_event     ev;
    } t_latch_req;

    typedef struct packed {
        logic       valid;
        logic [4:0] key;
    } t_read_req;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [4:0] lowest_set(input logic [31:0] v);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                idx = 5'(i);
            end
        end
        lowest_set = idx;
    endfunction

endpackage

### rtl/kcdl_scan.sv
// Debounce scan and click/double/long event state machine for the tracked key.
module kcdl_scan import kcdl_pkg::*; #(
    parameter int KEYS = KCDL_KEYS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_scan,
    input  logic [31:0] i_keys,
    input  logic [15:0] i_debounce,
    input  logic [15:0] i_long,
    input  logic [15:0] i_double,
    output t_event      o_tick_event,
    output logic [4:0]  o_key,
    output t_latch_req  o_latch
);

    localparam logic [32:0] MaskWide = (33'd1 << KEYS) - 33'd1;

    logic [31:0] r_snapshot, n_snapshot;
    logic [15:0] r_stable, n_stable;
    logic        r_track, n_track;
    logic [4:0]  r_tracked, n_tracked;
    t_phase      r_phase, n_phase;
    logic [15:0] r_release, n_release;
    logic [15:0] r_hold, n_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snapshot <= '0;
            r_stable   <= '0;
            r_track    <= 1'b0;
            r_tracked  <= '0;
            r_phase    <= PH_IDLE;
            r_release  <= '0;
            r_hold     <= '0;
        end else begin
            r_snapshot <= n_snapshot;
            r_stable   <= n_stable;
            r_track    <= n_track;
            r_tracked  <= n_tracked;
            r_phase    <= n_phase;
            r_release  <= n_release;
            r_hold     <= n_hold;
        end
    end

    always_comb begin
        logic [31:0] keys;
        logic        pressed;
        logic        tm;
        logic [15:0] inc_rel;
        logic [15:0] inc_hold;
        t_event      ev;
        keys       = i_keys & MaskWide[31:0];
        pressed    = keys[r_tracked];
        tm         = r_track && (r_snapshot != '0);
        inc_rel    = sat_inc(r_release);
        inc_hold   = sat_inc(r_hold);
        ev         = EV_NONE;
        n_snapshot = r_snapshot;
        n_stable   = r_stable;
        n_track    = r_track;
        n_tracked  = r_tracked;
        n_phase    = r_phase;
        n_release  = r_release;
        n_hold     = r_hold;
        if (i_scan) begin
            n_track = tm;
            if (!tm) begin
                if (keys == r_snapshot) begin
                    n_stable = sat_inc(r_stable);
                end else begin
                    n_snapshot = keys;
                    n_stable   = '0;
                end
                if (n_stable == i_debounce && n_snapshot != '0) begin
                    n_track   = 1'b1;
                    n_tracked = lowest_set(n_snapshot);
                end
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        if (pressed) begin
                            n_phase = PH_HELD;
                            n_hold  = '0;
                        end
                    end
                    PH_HELD: begin
                        if (!pressed) begin
                            n_release = inc_rel;
                            if (inc_rel > i_debounce) begin
                                n_release = '0;
                                n_hold    = '0;
                                n_phase   = PH_DOUBLE;
                            end
                        end else begin
                            n_hold = inc_hold;
                            if (inc_hold > i_long) begin
                                n_phase   = PH_LONG;
                                n_release = '0;
                            end
                        end
                    end
                    PH_LONG: begin
                        if (!pressed) begin
                            ev      = EV_LONG;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_DOUBLE: begin
                        if (pressed) begin
                            n_hold = inc_hold;
                            if (inc_hold == i_debounce) begin
                                ev      = EV_DOUBLE;
                                n_phase = PH_IDLE;
                            end
                        end else begin
                            n_release = inc_rel;
                            if (inc_rel > i_double) begin
                                n_hold  = '0;
                                ev      = EV_CLICK;
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
                if (ev != EV_NONE) begin
                    n_track = 1'b0;
                end
            end
        end
        o_tick_event  = ev;
        o_key         = n_tracked;
        o_latch.valid = (ev != EV_NONE);
        o_latch.key   = r_tracked;
        o_latch.ev    = ev;
    end

endmodule

### rtl/kcdl_store.sv
// Per-key latched event store with read-and-clear.
module kcdl_store import kcdl_pkg::*; #(
    parameter int KEYS = KCDL_KEYS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_latch_req i_latch,
    input  t_read_req  i_read,
    output logic [1:0] o_read_value
);

    localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;

    logic [1:0]    r_events [KEYS];
    logic [4:0]    addr;
    logic [KW-1:0] idx;
    logic          in_range;
    logic [1:0]    entry;

    assign addr     = i_read.valid ? i_read.key : i_latch.key;
    assign idx      = addr[KW-1:0];
    assign in_range = {1'b0, addr} < 6'(KEYS);
    assign entry    = in_range ? r_events[idx] : 2'd0;

    assign o_read_value = i_read.valid ? entry : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEYS; i++) begin
                r_events[i] <= 2'd0;
            end
        end else if (i_read.valid) begin
            if (in_range) begin
                r_events[idx] <= 2'd0;
            end
        end else if (i_latch.valid && in_range && entry == 2'd0) begin
            r_events[idx] <= i_latch.ev;
        end
    end

endmodule

### rtl/key_click_double_long_detector.sv
// Top level of the key click, double and long press detector.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+------------------------
//  input   | in        | i_in_valid / o_in_ready      | i_in  (t_in_item)
//  output  | out       | o_out_valid / i_out_ready    | o_out (t_out_item)
//  config  | in        | i_cfg_wr_en, no wait         | i_cfg_idx, i_cfg_data
//
// One transaction per cycle while the output side does not stall: the item is decoded in the accept cycle and its
// result is captured in the output register.
// The output register alone sets the rate; a held result blocks input only
// while the output side stalls.
// Synchronous active-low reset clears the scan state, the event store and
// loads the default timing registers; input is not accepted during reset.
`include "key_click_double_long_detector_macros.svh"

module key_click_double_long_detector import kcdl_pkg::*; #(
    parameter int KEYS = KCDL_KEYS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out
);

    logic [15:0] r_debounce;
    logic [15:0] r_long;
    logic [15:0] r_double;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        in_fire;
    logic        scan_fire;
    t_event      tick_event;
    logic [4:0]  event_key;
    t_latch_req  latch;
    t_read_req   read_req;
    logic [1:0]  read_value;

    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;
    assign scan_fire  = in_fire && (i_in.func == FUNC_SCAN);

    assign read_req.valid = in_fire && (i_in.func == FUNC_READ);
    assign read_req.key   = i_in.read_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_long     <= LONG_RESET;
            r_double   <= DOUBLE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_LONG:     r_long     <= i_cfg_data;
                CFG_DOUBLE:   r_double   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    kcdl_scan #(
        .KEYS (KEYS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scan       (scan_fire),
        .i_keys       (i_in.pressed_keys),
        .i_debounce   (r_debounce),
        .i_long       (r_long),
        .i_double     (r_double),
        .o_tick_event (tick_event),
        .o_key        (event_key),
        .o_latch      (latch)
    );

    kcdl_store #(
        .KEYS (KEYS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_latch      (latch),
        .i_read       (read_req),
        .o_read_value (read_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out.tick_event <= tick_event;
            r_out.event_key  <= event_key;
            r_out.read_value <= read_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `KCDL_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, in_fire, r_out_valid)
    `KCDL_ASSERT_NEXT(a_read_no_tick, i_clk, i_rst_n, read_req.valid, r_out.tick_event == EV_NONE)
    `KCDL_ASSERT_NEXT(a_scan_no_read, i_clk, i_rst_n, scan_fire, r_out.read_value == 2'd0)
    `KCDL_ASSERT_NOW(a_latch_on_scan, i_clk, i_rst_n, latch.valid, scan_fire)

endmodule
